FILE: hdl/ffse_pkg.sv
// ffse_pkg: shared sizes, request codes, controller states and command struct
// for the flit fifo with source extract; no dependencies
`default_nettype none

package ffse_pkg;

  localparam int DEPTH        = 16;
  localparam int SRC_BITS     = 8;
  localparam int PAYLOAD_BITS = 32;
  localparam int CAP_BITS     = 5;
  localparam int CAP_RESET    = 16;
  localparam int CNT_BITS     = $clog2(DEPTH + 1);
  localparam int IDX_BITS     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_EXTRACT = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic search;
    logic commit;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/ffse_channels.sv
// ffse_req_if and ffse_rsp_if: valid/ready channels for requests and responses
// depends on ffse_pkg
`default_nettype none

interface ffse_req_if import ffse_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic [SRC_BITS-1:0]     in_src;
  logic [PAYLOAD_BITS-1:0] in_payload;
  logic [SRC_BITS-1:0]     wanted_src;

  modport source (output valid, req_type, in_src, in_payload, wanted_src, input ready);
  modport sink   (input valid, req_type, in_src, in_payload, wanted_src, output ready);
endinterface

interface ffse_rsp_if import ffse_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    success;
  logic [SRC_BITS-1:0]     out_src;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [CNT_BITS-1:0]     free_slots;

  modport source (output valid, success, out_src, out_payload, free_slots, input ready);
  modport sink   (input valid, success, out_src, out_payload, free_slots, output ready);
endinterface

`default_nettype wire

FILE: hdl/ffse_ctrl.sv
// ffse_ctrl: request sequencer and response valid flag
// depends on ffse_pkg
`default_nettype none

module ffse_ctrl import ffse_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire        out_ready,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // wait until the response register is free
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.commit |=> out_valid)
    else $error("response not valid after commit");
  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |-> !cmd.commit)
    else $error("commit overwrote a pending response");
  assert property (@(posedge clk) disable iff (rst) cmd.capture |=> cmd.search)
    else $error("search did not follow capture");

endmodule

`default_nettype wire

FILE: hdl/ffse_dp.sv
// ffse_dp: flit slots, fill count, capacity register, source match and
// response register; depends on ffse_pkg
`default_nettype none

module ffse_dp import ffse_pkg::*; (
  input  wire                     clk,
  input  wire                     rst,
  input  ctrl_cmd_t               cmd,
  input  wire  [1:0]              req_type,
  input  wire  [SRC_BITS-1:0]     in_src,
  input  wire  [PAYLOAD_BITS-1:0] in_payload,
  input  wire  [SRC_BITS-1:0]     wanted_src,
  input  wire                     cfg_we,
  input  wire  [CAP_BITS-1:0]     cfg_data,
  output logic                    out_success,
  output logic [SRC_BITS-1:0]     out_src,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic [CNT_BITS-1:0]     out_free
);

  logic [CAP_BITS-1:0]     capacity;
  logic [CNT_BITS-1:0]     count, count_next;
  logic [CNT_BITS-1:0]     cap_eff;
  logic [SRC_BITS-1:0]     slot_src [DEPTH];
  logic [PAYLOAD_BITS-1:0] slot_payload [DEPTH];
  logic [SRC_BITS-1:0]     src_up [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_up [DEPTH];

  logic [1:0]              req_q;
  logic [SRC_BITS-1:0]     src_q;
  logic [PAYLOAD_BITS-1:0] payload_q;
  logic [SRC_BITS-1:0]     wanted_q;

  logic [DEPTH-1:0]        hit, first, mask_calc;
  logic [DEPTH-1:0]        sel, mask;
  logic                    enq_ok, rem_ok;
  logic [SRC_BITS-1:0]     rm_src;
  logic [PAYLOAD_BITS-1:0] rm_payload;
  logic [CNT_BITS-1:0]     free_next;

  always_comb begin
    if (32'(capacity) > DEPTH) begin
      cap_eff = CNT_BITS'(DEPTH);
    end else if (capacity == '0) begin
      cap_eff = CNT_BITS'(1);
    end else begin
      cap_eff = CNT_BITS'(capacity);
    end
  end

  // search stage: oldest matching slot as one-hot, plus the slots behind it
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = (CNT_BITS'(i) < count) &&
               (((req_q == REQ_EXTRACT) && (slot_src[i] == wanted_q)) ||
                ((req_q == REQ_DEQUEUE) && (i == 0)));
    end
    first     = hit & (~hit + DEPTH'(1));
    mask_calc = (first == '0) ? '0 : ~(first - DEPTH'(1));
  end

  // commit stage
  always_comb begin
    enq_ok     = (req_q == REQ_ENQUEUE) && (count < cap_eff);
    rem_ok     = |sel;
    rm_src     = '0;
    rm_payload = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rm_src     = rm_src     | (sel[i] ? slot_src[i]     : '0);
      rm_payload = rm_payload | (sel[i] ? slot_payload[i] : '0);
    end
    if (enq_ok) begin
      count_next = count + CNT_BITS'(1);
    end else if (rem_ok) begin
      count_next = count - CNT_BITS'(1);
    end else begin
      count_next = count;
    end
    free_next = (cap_eff > count_next) ? cap_eff - count_next : '0;
  end

  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      src_up[i] = slot_src[i+1];
      pay_up[i] = slot_payload[i+1];
    end
    src_up[DEPTH-1] = slot_src[DEPTH-1];
    pay_up[DEPTH-1] = slot_payload[DEPTH-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_BITS'(CAP_RESET);
      count    <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_data;
      count    <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q     <= req_type;
      src_q     <= in_src;
      payload_q <= in_payload;
      wanted_q  <= wanted_src;
    end
    if (cmd.search) begin
      sel  <= first;
      mask <= mask_calc;
    end
    if (cmd.commit) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (enq_ok && (count[IDX_BITS-1:0] == IDX_BITS'(i))) begin
          slot_src[i]     <= src_q;
          slot_payload[i] <= payload_q;
        end else if (mask[i]) begin
          slot_src[i]     <= src_up[i];
          slot_payload[i] <= pay_up[i];
        end
      end
      out_success <= enq_ok || rem_ok;
      out_src     <= rm_src;
      out_payload <= rm_payload;
      out_free    <= free_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_BITS'(DEPTH))
    else $error("fill count above depth");
  assert property (@(posedge clk) disable iff (rst) cmd.commit |-> $onehot0(sel))
    else $error("more than one slot selected for removal");
  assert property (@(posedge clk) disable iff (rst)
      (cmd.commit && !cfg_we && rem_ok) |=> count == $past(count) - CNT_BITS'(1))
    else $error("removal did not lower the fill count");
  assert property (@(posedge clk) disable iff (rst) cfg_we |=> count == '0)
    else $error("capacity write did not empty the buffer");

endmodule

`default_nettype wire

FILE: hdl/flit_fifo_with_source_extract.sv
// flit_fifo_with_source_extract: top level, bounded flit fifo with removal
// of the oldest flit from a given source; depends on ffse_pkg, ffse_channels,
// ffse_ctrl, ffse_dp
//
//   channel  dir  handshake       payload
//   req      in   valid/ready     req_type, in_src, in_payload, wanted_src
//   rsp      out  valid/ready     success, out_src, out_payload, free_slots
//   cfg      in   cfg_we only     cfg_data (capacity, 5 bits)
//
// each transaction runs in three steps: capture, a parallel source compare
// over all slots, then commit of the slot update and the response register
// the response register lets the next request be captured and searched while
// a response waits; the commit stage stalls until the register is free
// rst is synchronous: capacity returns to 16 and the buffer is empty
// slot contents have no reset; only slots below the fill count are read
`default_nettype none

module flit_fifo_with_source_extract import ffse_pkg::*; (
  input  wire                 clk,
  input  wire                 rst,
  ffse_req_if.sink            req,
  ffse_rsp_if.source          rsp,
  input  wire                 cfg_we,
  input  wire  [CAP_BITS-1:0] cfg_data
);

  ctrl_cmd_t cmd;

  // sequencer: owns request ready and response valid
  ffse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // storage, match logic and response fields
  ffse_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req.req_type),
    .in_src      (req.in_src),
    .in_payload  (req.in_payload),
    .wanted_src  (req.wanted_src),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .out_success (rsp.success),
    .out_src     (rsp.out_src),
    .out_payload (rsp.out_payload),
    .out_free    (rsp.free_slots)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench for flit_fifo_with_source_extract: directed table then random traffic,
// every response checked against hand-written values or a queue-based model of the flit buffer
// depends on ffse_pkg, ffse_channels and the top level of the block
`default_nettype none

module testbench import ffse_pkg::*; ();

  // request code the block does not define; it must change nothing
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 78;
  localparam int PHASE_COUNT   = 8;
  // three steps per request (capture, search, commit); the settle wait covers anything still in flight
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [1:0]              kind;
    logic [SRC_BITS-1:0]     src;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SRC_BITS-1:0]     wanted;
  } flit_req_t;

  typedef struct packed {
    logic [SRC_BITS-1:0]     src;
    logic [PAYLOAD_BITS-1:0] payload;
  } flit_t;

  typedef struct packed {
    logic                    ok;
    logic [SRC_BITS-1:0]     src;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [CNT_BITS-1:0]     free_cnt;
  } fifo_rsp_t;

  // one row of the directed table: either a capacity write or a request,
  // optionally with the response spelled out by hand
  typedef struct {
    bit                  is_cfg;
    logic [CAP_BITS-1:0] cap;
    flit_req_t           rq;
    bit                  typed;
    fifo_rsp_t           known;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we;
  logic [CAP_BITS-1:0] cfg_data;

  ffse_req_if req_ch ();
  ffse_rsp_if rsp_ch ();

  flit_fifo_with_source_extract u_top (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state: flits in arrival order, head at index 0
  flit_t               held_flits[$];
  logic [CAP_BITS-1:0] cap_shadow = CAP_BITS'(CAP_RESET);
  // responses still owed by the block, oldest first
  fifo_rsp_t           pending_rsp[$];
  stim_row_t           directed_rows[$];
  int                  errors = 0;
  int                  cycle_cnt = 0;
  bit                  send_quiet = 1'b0;
  bit                  recv_quiet = 1'b0;

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // capacity in use: zero acts as one, anything past the built depth as the depth
  function automatic int usable_slots();
    int c;
    c = cap_shadow;
    if (c > DEPTH) c = DEPTH;
    if (c == 0) c = 1;
    return c;
  endfunction

  // serve one transaction on the model buffer and return the response it owes
  function automatic fifo_rsp_t fifo_predict(flit_req_t rq);
    fifo_rsp_t r;
    flit_t     f;
    int        lim;
    int        hit;
    r   = '0;
    lim = usable_slots();
    hit = -1;
    case (rq.kind)
      REQ_ENQUEUE: begin
        if (held_flits.size() < lim) begin
          f.src     = rq.src;
          f.payload = rq.payload;
          held_flits.push_back(f);
          r.ok = 1'b1;
        end
      end
      REQ_DEQUEUE: begin
        if (held_flits.size() > 0) hit = 0;
      end
      REQ_EXTRACT: begin
        // oldest flit from the wanted source; later flits keep their order
        for (int i = 0; i < held_flits.size(); i++) begin
          if (hit < 0 && held_flits[i].src == rq.wanted) hit = i;
        end
      end
      default: ;
    endcase
    if (hit >= 0) begin
      r.ok      = 1'b1;
      r.src     = held_flits[hit].src;
      r.payload = held_flits[hit].payload;
      held_flits.delete(hit);
    end
    r.free_cnt = (held_flits.size() < lim) ? CNT_BITS'(lim - held_flits.size()) : '0;
    return r;
  endfunction

  // sources come mostly from a small pool so extracts find matches
  function automatic logic [SRC_BITS-1:0] pick_src();
    if ($urandom_range(0, 3) == 0) return SRC_BITS'($urandom_range(0, 255));
    return SRC_BITS'($urandom_range(0, 5));
  endfunction

  function automatic flit_req_t random_request(int enq_pct);
    flit_req_t rq;
    int        k;
    rq.src     = pick_src();
    rq.payload = PAYLOAD_BITS'($urandom);
    k = $urandom_range(0, 99);
    if (k < enq_pct) begin
      rq.kind = REQ_ENQUEUE;
    end else begin
      k = $urandom_range(0, 19);
      if (k == 0) rq.kind = REQ_UNUSED;
      else if (k < 9) rq.kind = REQ_DEQUEUE;
      else rq.kind = REQ_EXTRACT;
    end
    // usually search for a source that is really held somewhere in the buffer
    if (held_flits.size() > 0 && $urandom_range(0, 3) != 0)
      rq.wanted = held_flits[$urandom_range(0, held_flits.size() - 1)].src;
    else
      rq.wanted = pick_src();
    return rq;
  endfunction

  task automatic add_req(input logic [1:0] kind, input logic [SRC_BITS-1:0] src,
                         input logic [PAYLOAD_BITS-1:0] payload,
                         input logic [SRC_BITS-1:0] wanted, input bit typed,
                         input logic ok, input logic [SRC_BITS-1:0] osrc,
                         input logic [PAYLOAD_BITS-1:0] opay,
                         input logic [CNT_BITS-1:0] free_cnt);
    stim_row_t row;
    row.is_cfg         = 1'b0;
    row.cap            = '0;
    row.rq.kind        = kind;
    row.rq.src         = src;
    row.rq.payload     = payload;
    row.rq.wanted      = wanted;
    row.typed          = typed;
    row.known.ok       = ok;
    row.known.src      = osrc;
    row.known.payload  = opay;
    row.known.free_cnt = free_cnt;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [CAP_BITS-1:0] cap);
    stim_row_t row;
    row       = '{default: '0};
    row.is_cfg = 1'b1;
    row.cap    = cap;
    directed_rows.push_back(row);
  endtask

  // drop valid and hold off until the block owes nothing
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // capacity writes only land on an idle block; a write also empties the buffer
  task automatic write_capacity(input logic [CAP_BITS-1:0] v);
    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cap_shadow = v;
    held_flits.delete();
  endtask

  // one request transaction; valid stays up afterwards so back-to-back
  // requests need no idle gap
  task automatic issue_request(input flit_req_t rq, input bit typed,
                               input fifo_rsp_t known);
    int        gap;
    fifo_rsp_t r;
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= rq.kind;
    req_ch.in_src     <= rq.src;
    req_ch.in_payload <= rq.payload;
    req_ch.wanted_src <= rq.wanted;
    do @(posedge clk); while (!req_ch.ready);
    r = fifo_predict(rq);
    pending_rsp.push_back(typed ? known : r);
  endtask

  task automatic report_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
    end
  endtask

  // response side: random stalls, then take one transaction and check it
  initial begin : rsp_side
    int        stall;
    int        taken;
    fifo_rsp_t exp_r;
    taken = 0;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 25 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
      stall = recv_quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      taken++;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: response with nothing expected, ok %b src %h payload %h free %0d",
                 $time, rsp_ch.success, rsp_ch.out_src, rsp_ch.out_payload,
                 rsp_ch.free_slots);
      end else begin
        exp_r = pending_rsp.pop_front();
        report_field("success", 64'(exp_r.ok), 64'(rsp_ch.success));
        report_field("out_src", 64'(exp_r.src), 64'(rsp_ch.out_src));
        report_field("out_payload", 64'(exp_r.payload), 64'(rsp_ch.out_payload));
        report_field("free_slots", 64'(exp_r.free_cnt), 64'(rsp_ch.free_slots));
      end
    end
  end

  // request side: reset, directed table, random phases, wind-down
  initial begin : req_side
    flit_req_t           rq;
    int                  enq_pct;
    logic [CAP_BITS-1:0] phase_caps[PHASE_COUNT];
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_ENQUEUE;
    req_ch.in_src     <= '0;
    req_ch.in_payload <= '0;
    req_ch.wanted_src <= '0;
    cfg_we            <= 1'b0;
    cfg_data          <= '0;

    // directed table, starting from the reset capacity of 16
    // empty buffer: dequeue, extract and the unused code all fail with zeros
    add_req(REQ_DEQUEUE, 8'h00, 32'h0, 8'h00, 1'b1, 1'b0, 8'h00, 32'h0, 5'd16);
    add_req(REQ_EXTRACT, 8'h00, 32'h0, 8'h00, 1'b1, 1'b0, 8'h00, 32'h0, 5'd16);
    add_req(REQ_UNUSED, 8'hff, 32'hffffffff, 8'hff, 1'b1, 1'b0, 8'h00, 32'h0, 5'd16);
    // field extremes on enqueue
    add_req(REQ_ENQUEUE, 8'h00, 32'h00000000, 8'h00, 1'b1, 1'b1, 8'h00, 32'h0, 5'd15);
    add_req(REQ_ENQUEUE, 8'hff, 32'hffffffff, 8'hff, 1'b1, 1'b1, 8'h00, 32'h0, 5'd14);
    add_req(REQ_ENQUEUE, 8'h5e, 32'h12345678, 8'h00, 1'b1, 1'b1, 8'h00, 32'h0, 5'd13);
    add_req(REQ_ENQUEUE, 8'hff, 32'ha5a5a5a5, 8'h00, 1'b1, 1'b1, 8'h00, 32'h0, 5'd12);
    add_req(REQ_ENQUEUE, 8'h5e, 32'h0000ffff, 8'h00, 1'b0, 1'b0, 8'h00, 32'h0, 5'd0);
    // extract from the middle picks the oldest of two matches
    add_req(REQ_EXTRACT, 8'h00, 32'h0, 8'hff, 1'b1, 1'b1, 8'hff, 32'hffffffff, 5'd12);
    // no source match leaves the buffer alone
    add_req(REQ_EXTRACT, 8'h00, 32'h0, 8'h77, 1'b1, 1'b0, 8'h00, 32'h0, 5'd12);
    add_req(REQ_EXTRACT, 8'h00, 32'h0, 8'h5e, 1'b0, 1'b0, 8'h00, 32'h0, 5'd0);
    add_req(REQ_DEQUEUE, 8'h00, 32'h0, 8'h00, 1'b1, 1'b1, 8'h00, 32'h0, 5'd14);
    add_req(REQ_UNUSED, 8'h81, 32'h80000001, 8'h5e, 1'b0, 1'b0, 8'h00, 32'h0, 5'd0);
    // extract of the tail entry
    add_req(REQ_EXTRACT, 8'h00, 32'h0, 8'h5e, 1'b0, 1'b0, 8'h00, 32'h0, 5'd0);
    add_req(REQ_DEQUEUE, 8'h00, 32'h0, 8'h00, 1'b1, 1'b1, 8'hff, 32'ha5a5a5a5, 5'd16);
    // capacity zero acts as one slot: second enqueue hits a full buffer
    add_cfg(5'd0);
    add_req(REQ_ENQUEUE, 8'h3c, 32'hdeadbeef, 8'h00, 1'b1, 1'b1, 8'h00, 32'h0, 5'd0);
    add_req(REQ_ENQUEUE, 8'h3c, 32'h00000001, 8'h00, 1'b1, 1'b0, 8'h00, 32'h0, 5'd0);
    add_req(REQ_EXTRACT, 8'h00, 32'h0, 8'h3c, 1'b1, 1'b1, 8'h3c, 32'hdeadbeef, 5'd1);
    // capacity above the depth is clamped to 16
    add_cfg(5'd31);
    add_req(REQ_ENQUEUE, 8'h01, 32'h80000000, 8'h00, 1'b1, 1'b1, 8'h00, 32'h0, 5'd15);
    // a capacity write empties the buffer
    add_cfg(5'd2);
    add_req(REQ_DEQUEUE, 8'h00, 32'h0, 8'h00, 1'b1, 1'b0, 8'h00, 32'h0, 5'd2);
    add_req(REQ_ENQUEUE, 8'hc3, 32'h55aa55aa, 8'h00, 1'b0, 1'b0, 8'h00, 32'h0, 5'd0);
    add_req(REQ_ENQUEUE, 8'h81, 32'h7fffffff, 8'h00, 1'b0, 1'b0, 8'h00, 32'h0, 5'd0);
    add_req(REQ_ENQUEUE, 8'h00, 32'hffffffff, 8'h00, 1'b0, 1'b0, 8'h00, 32'h0, 5'd0);

    // capacity settings for the random phases, extremes included
    phase_caps[0] = 5'd16;
    phase_caps[1] = 5'd1;
    phase_caps[2] = 5'd4;
    phase_caps[3] = 5'd0;
    phase_caps[4] = 5'd31;
    phase_caps[5] = 5'd17;
    phase_caps[6] = CAP_BITS'($urandom_range(0, 31));
    phase_caps[7] = 5'd8;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_capacity(directed_rows[i].cap);
      else issue_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].known);
    end

    // random phases; the enqueue share drifts so the buffer swings
    // between empty and full within each phase
    enq_pct = 50;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_capacity(phase_caps[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 26 == 0) enq_pct = $urandom_range(25, 75);
        if (n % 30 == 0) send_quiet = ($urandom_range(0, 3) == 0);
        // mid-phase hold-off until the block has answered everything
        if (n == 39) drain_responses();
        rq = random_request(enq_pct);
        issue_request(rq, 1'b0, '0);
      end
    end

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
